@@ rtl/tlpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpc_pkg
// shared types and constants of the tank level pump controller
// ----------------------------------------------------------------------------
package tlpc_pkg;

   localparam int SENSOR_COUNT_DEFAULT = 4;
   localparam int PERIOD_WIDTH         = 16;

   localparam logic [PERIOD_WIDTH-1:0] BLINK_PERIOD_RESET = PERIOD_WIDTH'(500);
   localparam logic [PERIOD_WIDTH-1:0] WAIT_COUNT_MAX     = {PERIOD_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      MODE_STARTUP = 2'd0,
      MODE_IDLE    = 2'd1,
      MODE_PUMPING = 2'd2,
      MODE_ERROR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_ON  = 2'd0,
      PH_RUN = 2'd1,
      PH_OFF = 2'd2
   } pump_phase_type;

   typedef enum logic {
      ERR_SHOW = 1'b0,
      ERR_WAIT = 1'b1
   } error_phase_type;

   // fixed-width part of one result item
   typedef struct packed {
      logic     green_led;
      logic     red_led;
      logic     pump_drive;
      mode_type mode;
      logic     watch_direction;
      logic     error_blink_start;
   } status_type;

endpackage

@@ rtl/tlpc_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpc_req_if
// tick channel: sensor levels and pending edge flags
// ----------------------------------------------------------------------------
interface tlpc_req_if #(
   parameter int SENSOR_COUNT = tlpc_pkg::SENSOR_COUNT_DEFAULT
);
   logic                    valid;
   logic                    ready;
   logic [SENSOR_COUNT-1:0] sensor_levels;
   logic [SENSOR_COUNT-1:0] edge_flags;

   modport source (output valid, output sensor_levels, output edge_flags, input ready);
   modport sink   (input valid, input sensor_levels, input edge_flags, output ready);
endinterface

@@ rtl/tlpc_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpc_rsp_if
// result channel: led, pump and mode outputs after each tick
// ----------------------------------------------------------------------------
interface tlpc_rsp_if #(
   parameter int SENSOR_COUNT = tlpc_pkg::SENSOR_COUNT_DEFAULT
);
   logic                    valid;
   logic                    ready;
   logic [SENSOR_COUNT-1:0] sensor_leds;
   logic                    green_led;
   logic                    red_led;
   logic                    pump_drive;
   logic [1:0]              mode;
   logic [SENSOR_COUNT-1:0] fault_mask;
   logic                    watch_direction;
   logic                    error_blink_start;

   modport source (output valid, output sensor_leds, output green_led, output red_led,
                   output pump_drive, output mode, output fault_mask,
                   output watch_direction, output error_blink_start, input ready);
   modport sink   (input valid, input sensor_leds, input green_led, input red_led,
                   input pump_drive, input mode, input fault_mask,
                   input watch_direction, input error_blink_start, output ready);
endinterface

@@ rtl/tlpc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpc_ctrl
// controller state and per-tick update; the state doubles as the result
// ----------------------------------------------------------------------------
module tlpc_ctrl #(
   parameter int SENSOR_COUNT = tlpc_pkg::SENSOR_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [SENSOR_COUNT-1:0]           levels,
   input  logic [SENSOR_COUNT-1:0]           edges,
   input  logic [tlpc_pkg::PERIOD_WIDTH-1:0] blink_period,
   output logic [SENSOR_COUNT-1:0]           sensor_leds,
   output logic [SENSOR_COUNT-1:0]           fault_mask,
   output tlpc_pkg::status_type              status
);

   localparam logic [SENSOR_COUNT-1:0] BOTTOM_EDGE = SENSOR_COUNT'(1);
   localparam logic [SENSOR_COUNT-1:0] TOP_EDGE    = {1'b1, {(SENSOR_COUNT-1){1'b0}}};

   tlpc_pkg::mode_type        mode_ff,      mode_in;
   tlpc_pkg::pump_phase_type  phase_ff,     phase_in;
   tlpc_pkg::error_phase_type err_phase_ff, err_phase_in;

   logic [SENSOR_COUNT-1:0]           faults_ff, faults_in;
   logic [SENSOR_COUNT-1:0]           leds_ff, leds_in;
   logic [tlpc_pkg::PERIOD_WIDTH-1:0] blink_cnt_ff, blink_cnt_in;
   logic [tlpc_pkg::PERIOD_WIDTH-1:0] wait_cnt_ff, wait_cnt_in;
   logic                              green_ff, green_in;
   logic                              red_ff, red_in;
   logic                              pump_ff, pump_in;
   logic                              dir_ff, dir_in;
   logic                              pulse_ff, pulse_in;

   logic [SENSOR_COUNT-1:0]           startup_faults;
   logic [tlpc_pkg::PERIOD_WIDTH-1:0] blink_inc;
   logic [tlpc_pkg::PERIOD_WIDTH-1:0] wait_inc;

   // dry sensor with any wet sensor above it
   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         startup_faults[i] = ~levels[i] & (|(levels >> (i + 1)));
      end
   end

   assign blink_inc = blink_cnt_ff + 1'b1;
   assign wait_inc  = wait_cnt_ff + 1'b1;

   // next state
   always_comb begin
      mode_in      = mode_ff;
      phase_in     = phase_ff;
      err_phase_in = err_phase_ff;
      unique case (mode_ff)
         tlpc_pkg::MODE_STARTUP: begin
            if (|startup_faults) begin
               mode_in      = tlpc_pkg::MODE_ERROR;
               err_phase_in = tlpc_pkg::ERR_SHOW;
            end else if (!levels[0]) begin
               mode_in  = tlpc_pkg::MODE_PUMPING;
               phase_in = tlpc_pkg::PH_ON;
            end else begin
               mode_in = tlpc_pkg::MODE_IDLE;
            end
         end
         tlpc_pkg::MODE_IDLE: begin
            if (edges == BOTTOM_EDGE) begin
               mode_in  = tlpc_pkg::MODE_PUMPING;
               phase_in = tlpc_pkg::PH_ON;
            end
         end
         tlpc_pkg::MODE_PUMPING: begin
            unique case (phase_ff)
               tlpc_pkg::PH_ON:  phase_in = tlpc_pkg::PH_RUN;
               tlpc_pkg::PH_RUN: begin
                  if (edges == TOP_EDGE) phase_in = tlpc_pkg::PH_OFF;
               end
               tlpc_pkg::PH_OFF: mode_in = tlpc_pkg::MODE_IDLE;
               default: ;
            endcase
         end
         tlpc_pkg::MODE_ERROR: begin
            if (err_phase_ff == tlpc_pkg::ERR_SHOW) err_phase_in = tlpc_pkg::ERR_WAIT;
         end
      endcase
   end

   // outputs and counters
   always_comb begin
      faults_in    = faults_ff;
      leds_in      = leds_ff;
      blink_cnt_in = blink_cnt_ff;
      wait_cnt_in  = wait_cnt_ff;
      green_in     = green_ff;
      red_in       = red_ff;
      pump_in      = pump_ff;
      dir_in       = dir_ff;
      pulse_in     = 1'b0;
      unique case (mode_ff)
         tlpc_pkg::MODE_STARTUP: begin
            leds_in = leds_ff | levels;
            if (|startup_faults) begin
               faults_in = startup_faults;
            end else begin
               green_in = 1'b1;
               dir_in   = levels[0];
            end
         end
         tlpc_pkg::MODE_IDLE: begin
            leds_in = leds_ff & ~edges;
            if (edges == BOTTOM_EDGE) dir_in = 1'b0;
         end
         tlpc_pkg::MODE_PUMPING: begin
            unique case (phase_ff)
               tlpc_pkg::PH_ON: pump_in = 1'b1;
               tlpc_pkg::PH_RUN: begin
                  leds_in      = leds_ff | edges;
                  blink_cnt_in = blink_inc;
                  if (blink_inc == blink_period) begin
                     green_in     = ~green_ff;
                     blink_cnt_in = '0;
                  end
               end
               tlpc_pkg::PH_OFF: begin
                  pump_in  = 1'b0;
                  green_in = 1'b1;
                  dir_in   = 1'b1;
               end
               default: ;
            endcase
         end
         tlpc_pkg::MODE_ERROR: begin
            if (err_phase_ff == tlpc_pkg::ERR_SHOW) begin
               leds_in  = '0;
               green_in = 1'b1;
               red_in   = 1'b1;
            end else if (wait_cnt_ff != tlpc_pkg::WAIT_COUNT_MAX) begin
               wait_cnt_in = wait_inc;
               pulse_in    = (wait_inc == blink_period);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= tlpc_pkg::MODE_STARTUP;
         phase_ff     <= tlpc_pkg::PH_ON;
         err_phase_ff <= tlpc_pkg::ERR_SHOW;
         faults_ff    <= '0;
         leds_ff      <= '0;
         blink_cnt_ff <= '0;
         wait_cnt_ff  <= '0;
         green_ff     <= 1'b0;
         red_ff       <= 1'b0;
         pump_ff      <= 1'b0;
         dir_ff       <= 1'b0;
         pulse_ff     <= 1'b0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         err_phase_ff <= err_phase_in;
         faults_ff    <= faults_in;
         leds_ff      <= leds_in;
         blink_cnt_ff <= blink_cnt_in;
         wait_cnt_ff  <= wait_cnt_in;
         green_ff     <= green_in;
         red_ff       <= red_in;
         pump_ff      <= pump_in;
         dir_ff       <= dir_in;
         pulse_ff     <= pulse_in;
      end
   end

   assign sensor_leds              = leds_ff;
   assign fault_mask               = faults_ff;
   assign status.green_led         = green_ff;
   assign status.red_led           = red_ff;
   assign status.pump_drive        = pump_ff;
   assign status.mode              = mode_ff;
   assign status.watch_direction   = dir_ff;
   assign status.error_blink_start = pulse_ff;

endmodule

@@ rtl/tank_level_pump_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tank_level_pump_controller_unit
// level sensor supervision and pump control, one tick per item
// ----------------------------------------------------------------------------
// path: an accepted tick waits in the input register, then its state update lands in the result
// throughput: one item per cycle while rsp does not stall, set by the state update
// the controller state registers are the result register, held while rsp stalls
// reset: synchronous active high, startup mode, all outputs off, blink period 500
// ----------------------------------------------------------------------------
module tank_level_pump_controller_unit #(
   parameter int SENSOR_COUNT = tlpc_pkg::SENSOR_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   tlpc_req_if.sink                          req_if,
   tlpc_rsp_if.source                        rsp_if,
   input  logic                              csr_wr_en,
   input  logic [tlpc_pkg::PERIOD_WIDTH-1:0] csr_wr_data
);

   // input register
   logic                    in_valid_ff, in_valid_in;
   logic [SENSOR_COUNT-1:0] in_levels_ff;
   logic [SENSOR_COUNT-1:0] in_edges_ff;

   // result handshake
   logic rsp_valid_ff, rsp_valid_in;

   // blink period register
   logic [tlpc_pkg::PERIOD_WIDTH-1:0] period_ff, period_in;

   logic                    advance;
   logic                    req_accept;
   logic [SENSOR_COUNT-1:0] leds;
   logic [SENSOR_COUNT-1:0] faults;
   tlpc_pkg::status_type    status;

   // the buffered tick moves into the state when the result slot is free or taken
   assign advance      = in_valid_ff & (~rsp_valid_ff | rsp_if.ready);
   assign req_if.ready = ~in_valid_ff | advance;
   assign req_accept   = req_if.valid & req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign period_in = csr_wr_en ? csr_wr_data : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= tlpc_pkg::BLINK_PERIOD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
      end
   end

   // tick payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_levels_ff <= req_if.sensor_levels;
         in_edges_ff  <= req_if.edge_flags;
      end
   end

   // mode sequencing, led latch, counters
   tlpc_ctrl #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .levels       (in_levels_ff),
      .edges        (in_edges_ff),
      .blink_period (period_ff),
      .sensor_leds  (leds),
      .fault_mask   (faults),
      .status       (status)
   );

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.sensor_leds       = leds;
   assign rsp_if.fault_mask        = faults;
   assign rsp_if.green_led         = status.green_led;
   assign rsp_if.red_led           = status.red_led;
   assign rsp_if.pump_drive        = status.pump_drive;
   assign rsp_if.mode              = status.mode;
   assign rsp_if.watch_direction   = status.watch_direction;
   assign rsp_if.error_blink_start = status.error_blink_start;

endmodule

@@ sim/tb_tank_level_pump_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tank_level_pump_controller_unit
// self-checking bench: every tick item sent is run through a cycle-free model
// of the controller, and each result item is compared field by field with the
// oldest predicted one. A directed start covers the startup path and the edge
// handling in idle, pumping and error; random phases follow, two with stalls
// of sender and receiver, and the blink period is rewritten in each phase.
// ----------------------------------------------------------------------------
module tb_tank_level_pump_controller_unit;
   import tlpc_pkg::*;

   localparam int SENSORS = SENSOR_COUNT_DEFAULT;

   typedef logic [SENSORS-1:0]      sensor_bits_t;
   typedef logic [PERIOD_WIDTH-1:0] period_t;

   localparam sensor_bits_t BOTTOM_EDGE = sensor_bits_t'(1);
   localparam sensor_bits_t TOP_EDGE    = sensor_bits_t'(1) << (SENSORS - 1);

   // one result item as the controller should show it
   typedef struct {
      sensor_bits_t sensor_leds;
      logic         green_led;
      logic         red_led;
      logic         pump_drive;
      mode_type     mode;
      sensor_bits_t fault_mask;
      logic         watch_direction;
      logic         error_blink_start;
   } tick_result_t;

   logic    clock;
   logic    reset;
   logic    csr_wr_en;
   period_t csr_wr_data;

   tlpc_req_if #(.SENSOR_COUNT(SENSORS)) req_ch ();
   tlpc_rsp_if #(.SENSOR_COUNT(SENSORS)) rsp_ch ();

   tank_level_pump_controller_unit #(.SENSOR_COUNT(SENSORS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // controller model state
   mode_type        ctl_mode;
   pump_phase_type  pump_ph;
   error_phase_type err_ph;
   sensor_bits_t    fault_bits;
   sensor_bits_t    led_bits;
   logic            green_on;
   logic            red_on;
   logic            pump_on;
   logic            watch_down;
   period_t         blink_period;
   period_t         blink_count;
   period_t         wait_count;

   tick_result_t outputs_due[$];

   int    mismatches;
   int    ticks_sent;
   int    results_checked;
   int    pump_runs;
   int    green_toggles;
   int    blink_requests;
   int    period_writes;
   int    sender_idle_pct;
   int    receiver_idle_pct;
   string startup_path;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // controller model
   // ---------------------------------------------------------------------------
   task automatic reset_model();
      ctl_mode     = MODE_STARTUP;
      pump_ph      = PH_ON;
      err_ph       = ERR_SHOW;
      fault_bits   = '0;
      led_bits     = '0;
      green_on     = 1'b0;
      red_on       = 1'b0;
      pump_on      = 1'b0;
      watch_down   = 1'b0;
      blink_period = BLINK_PERIOD_RESET;
      blink_count  = '0;
      wait_count   = '0;
   endtask

   function automatic void start_pumping();
      ctl_mode   = MODE_PUMPING;
      pump_ph    = PH_ON;
      watch_down = 1'b0;
      pump_runs++;
   endfunction

   function automatic tick_result_t advance_controller(input sensor_bits_t levels,
                                                       input sensor_bits_t edges);
      tick_result_t r;
      sensor_bits_t faults;
      logic         wet_above;
      logic         pulse;
      int           i;
      faults    = '0;
      wet_above = 1'b0;
      pulse     = 1'b0;
      case (ctl_mode)
         MODE_STARTUP: begin
            // a dry sensor under a wet one cannot be right
            for (i = SENSORS - 1; i >= 0; i--) begin
               if (levels[i]) begin
                  led_bits[i] = 1'b1;
                  wet_above   = 1'b1;
               end else if (wet_above) begin
                  faults[i] = 1'b1;
               end
            end
            if (faults != '0) begin
               ctl_mode   = MODE_ERROR;
               fault_bits = faults;
               err_ph     = ERR_SHOW;
            end else begin
               if (!levels[0]) begin
                  start_pumping();
               end else begin
                  ctl_mode   = MODE_IDLE;
                  watch_down = 1'b1;
               end
               green_on = 1'b1;
            end
         end
         MODE_IDLE: begin
            if (edges != '0) begin
               led_bits &= ~edges;
               if (edges == BOTTOM_EDGE) start_pumping();
            end
         end
         MODE_PUMPING: begin
            case (pump_ph)
               PH_ON: begin
                  pump_on = 1'b1;
                  pump_ph = PH_RUN;
               end
               PH_RUN: begin
                  blink_count = blink_count + 1'b1;
                  if (edges != '0) begin
                     led_bits |= edges;
                     if (edges == TOP_EDGE) pump_ph = PH_OFF;
                  end
                  if (blink_count == blink_period) begin
                     green_on    = ~green_on;
                     blink_count = '0;
                     green_toggles++;
                  end
               end
               PH_OFF: begin
                  pump_on    = 1'b0;
                  green_on   = 1'b1;
                  watch_down = 1'b1;
                  ctl_mode   = MODE_IDLE;
               end
               default: ;
            endcase
         end
         default: begin
            if (err_ph == ERR_SHOW) begin
               led_bits = '0;
               green_on = 1'b1;
               red_on   = 1'b1;
               err_ph   = ERR_WAIT;
            end else if (wait_count < WAIT_COUNT_MAX) begin
               // saturating count, so at most one request per period setting
               wait_count = wait_count + 1'b1;
               if (wait_count == blink_period) begin
                  pulse = 1'b1;
                  blink_requests++;
               end
            end
         end
      endcase
      r.sensor_leds       = led_bits;
      r.green_led         = green_on;
      r.red_led           = red_on;
      r.pump_drive        = pump_on;
      r.mode              = ctl_mode;
      r.fault_mask        = fault_bits;
      r.watch_direction   = watch_down;
      r.error_blink_start = pulse;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("%0t: result %0d %s: got %0d, expected %0d",
               $time, results_checked, what, got, want);
   endtask

   always @(posedge clock) begin
      tick_result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (outputs_due.size() == 0) begin
            report_mismatch("arrived with no tick pending, mode", rsp_ch.mode, -1);
         end else begin
            want = outputs_due.pop_front();
            if (rsp_ch.sensor_leds !== want.sensor_leds)
               report_mismatch("sensor_leds", rsp_ch.sensor_leds, want.sensor_leds);
            if (rsp_ch.green_led !== want.green_led)
               report_mismatch("green_led", rsp_ch.green_led, want.green_led);
            if (rsp_ch.red_led !== want.red_led)
               report_mismatch("red_led", rsp_ch.red_led, want.red_led);
            if (rsp_ch.pump_drive !== want.pump_drive)
               report_mismatch("pump_drive", rsp_ch.pump_drive, want.pump_drive);
            if (rsp_ch.mode !== want.mode)
               report_mismatch("mode", rsp_ch.mode, want.mode);
            if (rsp_ch.fault_mask !== want.fault_mask)
               report_mismatch("fault_mask", rsp_ch.fault_mask, want.fault_mask);
            if (rsp_ch.watch_direction !== want.watch_direction)
               report_mismatch("watch_direction", rsp_ch.watch_direction,
                               want.watch_direction);
            if (rsp_ch.error_blink_start !== want.error_blink_start)
               report_mismatch("error_blink_start", rsp_ch.error_blink_start,
                               want.error_blink_start);
         end
         results_checked++;
      end
   end

   // receiver stalls at the rate of the current phase
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic drive_tick(input sensor_bits_t levels, input sensor_bits_t edges);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.sensor_levels <= levels;
      req_ch.edge_flags    <= edges;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      outputs_due.push_back(advance_controller(levels, edges));
      ticks_sent++;
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
   endtask

   // the period register only changes while no tick is in flight
   task automatic write_blink_period(input period_t value);
      hold_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      blink_period = value;
      period_writes++;
   endtask

   // mostly a period one to eight ticks past the running count, so toggles and
   // blink requests keep coming; sometimes 1 to 6, zero, the maximum or 2 to 40
   function automatic period_t pick_period();
      period_t running;
      int      roll;
      running = (ctl_mode == MODE_ERROR) ? wait_count : blink_count;
      roll    = $urandom_range(99);
      if (roll < 55) return running + period_t'($urandom_range(8, 1));
      if (roll < 70) return period_t'($urandom_range(6, 1));
      if (roll < 80) return '0;
      if (roll < 90) return '1;
      return period_t'($urandom_range(40, 2));
   endfunction

   // edges shaped after the mode: idle mostly sees the bottom edge, a pumping
   // run mostly quiet ticks and fill edges until the top edge ends it
   function automatic sensor_bits_t pick_edges();
      int roll;
      roll = $urandom_range(99);
      if (ctl_mode == MODE_IDLE)
         return (roll < 65) ? BOTTOM_EDGE : sensor_bits_t'($urandom);
      if (ctl_mode == MODE_PUMPING && pump_ph == PH_RUN) begin
         if (roll < 7) return TOP_EDGE;
         if (roll < 15) return sensor_bits_t'($urandom);
         if (roll < 30) return sensor_bits_t'(1) << $urandom_range(SENSORS - 2, 1);
         return '0;
      end
      if (ctl_mode == MODE_PUMPING)
         return (roll < 70) ? sensor_bits_t'(0) : sensor_bits_t'($urandom);
      return sensor_bits_t'($urandom);
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------
   // the startup tick decides the path for the whole run, the seed picks it:
   // dry tank, consistent partial or full fill, or a sensor pattern with a fault
   task automatic test_startup();
      sensor_bits_t levels;
      int           roll;
      roll = $urandom_range(99);
      if (roll < 50) begin
         levels = '0;
      end else if (roll < 75) begin
         levels = (sensor_bits_t'(1) << $urandom_range(SENSORS - 1, 1)) - 1'b1;
         if ($urandom_range(1)) levels = '1;
      end else begin
         levels = sensor_bits_t'($urandom);
         while ((levels & (levels + 1'b1)) == '0) levels = sensor_bits_t'($urandom);
      end
      write_blink_period(period_t'(3));
      drive_tick(levels, sensor_bits_t'($urandom));
      startup_path = ctl_mode.name();
   endtask

   task automatic test_idle_edges();
      sensor_bits_t steps[5];
      int           guard;
      if (ctl_mode == MODE_ERROR) return;
      // leave a pumping run through its top edge first
      guard = 0;
      while (ctl_mode != MODE_IDLE && guard < 4) begin
         drive_tick('1, TOP_EDGE);
         guard++;
      end
      // several edges clear leds without starting the pump, then the bottom edge starts it
      steps = '{sensor_bits_t'(4'b0110), TOP_EDGE, sensor_bits_t'(4'b0011), '0, BOTTOM_EDGE};
      foreach (steps[i]) drive_tick(i[0] ? '1 : '0, steps[i]);
   endtask

   task automatic test_pump_cycle();
      sensor_bits_t steps[10];
      if (ctl_mode != MODE_PUMPING) return;
      // top edge ignored while the pump turns on, several edges never stop it,
      // the bottom edge ignored while it turns off
      steps = '{TOP_EDGE, '0, sensor_bits_t'(4'b0010), sensor_bits_t'(4'b0100),
                sensor_bits_t'(4'b1100), '1, '0, TOP_EDGE, BOTTOM_EDGE, '0};
      foreach (steps[i]) drive_tick(i[0] ? '0 : '1, steps[i]);
   endtask

   task automatic test_error_request();
      int k;
      if (ctl_mode != MODE_ERROR) return;
      for (k = 0; k < 5; k++) drive_tick(k[0] ? '1 : '0, k[0] ? '0 : '1);
      // zero never requests, a period below the count waits for nothing
      write_blink_period('0);
      drive_tick('1, '1);
      drive_tick('0, '0);
      write_blink_period(period_t'(1));
      drive_tick('0, '1);
      drive_tick('1, '0);
      write_blink_period(wait_count + period_t'(2));
      for (k = 0; k < 3; k++) drive_tick(sensor_bits_t'($urandom), sensor_bits_t'($urandom));
   endtask

   task automatic test_random_ticks(input int count, input int send_idle,
                                    input int recv_idle, input period_t first_period);
      int k;
      sender_idle_pct   = send_idle;
      receiver_idle_pct = recv_idle;
      for (k = 0; k < count; k++) begin
         if (k == 0) write_blink_period(first_period);
         else if (k % 70 == 0) write_blink_period(pick_period());
         drive_tick(sensor_bits_t'($urandom), pick_edges());
      end
   endtask

   initial begin
      #5_000_000;
      $display("run timed out, %0d results still pending", outputs_due.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_ch.valid         = 1'b0;
      req_ch.sensor_levels = '0;
      req_ch.edge_flags    = '0;
      mismatches           = 0;
      ticks_sent           = 0;
      results_checked      = 0;
      pump_runs            = 0;
      green_toggles        = 0;
      blink_requests       = 0;
      period_writes        = 0;
      sender_idle_pct      = 0;
      receiver_idle_pct    = 0;
      startup_path         = "";
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_startup();
      test_idle_edges();
      test_pump_cycle();
      test_error_request();
      test_random_ticks(283, 23, 53, period_t'(1));
      test_random_ticks(283, 53, 23, '1);
      test_random_ticks(284, 0, 0, '0);

      hold_until_drained();
      repeat (8) @(posedge clock);
      $display("%0d ticks, %0d results checked, startup went to %s, %0d period writes",
               ticks_sent, results_checked, startup_path, period_writes);
      $display("%0d pump runs, %0d green toggles, %0d error blink requests",
               pump_runs, green_toggles, blink_requests);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/tlpc_pkg.sv
rtl/tlpc_req_if.sv
rtl/tlpc_rsp_if.sv
rtl/tlpc_ctrl.sv
rtl/tank_level_pump_controller_unit.sv
sim/tb_tank_level_pump_controller_unit.sv
